### hw/rtl/tpcc_pkg.sv
// Shared types, codes and defaults for the two-phase commit coordinator.
// No dependencies.
package tpcc_pkg;

  localparam int DefMaxTxns  = 8;
  localparam int DefMaxParts = 4;
  localparam int DefIdBits   = 16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_VOTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_STARTED  = 3'd0,
    K_COMMIT   = 3'd1,
    K_ROLLBACK = 3'd2,
    K_DONE     = 3'd3,
    K_FAILED   = 3'd4,
    K_REFUSED  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SEXEC,
    S_VSCAN,
    S_VMRD,
    S_VMEXEC,
    S_TRD,
    S_TEXEC,
    S_FRD,
    S_FEMIT,
    S_FEND,
    S_OUT
  } state_t;

endpackage

### hw/rtl/two_phase_commit_coordinator.sv
// Two-phase commit coordinator: sequencer over slot and participant memories.
// Depends on tpcc_pkg, tpcc_slot_mem, tpcc_member_mem.
//
// Usage: one item enters on the in_ channel; its results leave one beat at a
// time on the out_ channel, out_last marking the final beat for that item.
// Items that cause no result simply retire. One item is in work at a time and
// in_ready stays low while a result beat waits. A start item reads the member
// row of its slot, then places the participant; the last member of a run
// closes it and sends its result beat. A vote scans the slots for its txn
// id and reads the member row, then emits and frees when the vote decides
// the txn. A tick advances the timer of each active slot, then emits and
// frees each expired slot. Emission walks the member entries one at a time,
// and a result beat that out_ready holds stalls it. Reset clears the
// active and used bits, the id counter and the start run; memory contents need
// no clearing since nothing reads an entry that is not marked used/active.
module two_phase_commit_coordinator import tpcc_pkg::*; #(
  parameter int MAX_TXNS  = DefMaxTxns,
  parameter int MAX_PARTS = DefMaxParts,
  parameter int ID_BITS   = DefIdBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_txn_id,
  input  logic [15:0] in_participant_id,
  input  logic        in_success,
  input  logic        in_last_member,
  input  logic [15:0] in_timeout_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_result_txn,
  output logic [15:0] out_target_participant,
  output logic        out_last
);

  localparam int SW = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
  localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_TXNS + 1);
  localparam int QW = $clog2(MAX_PARTS + 1);

  state_t state_r, state_nxt;

  logic [15:0] tid_r, pid_r, tmo_r;
  logic        succ_r, lastm_r;
  logic [ID_BITS-1:0] idc_r, idc_nxt;
  logic [SW-1:0] bslot_r, bslot_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [MAX_TXNS-1:0] exp_r, exp_nxt;
  logic        bopen_r, bopen_nxt, bovf_r, bovf_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [QW-1:0] m_r, m_nxt;
  logic        commit_r, commit_nxt;
  logic [15:0] ftxn_r, ftxn_nxt;
  logic [MAX_PARTS*16-1:0] fid_r, fid_nxt;
  logic [MAX_PARTS-1:0] frdy_r, frdy_nxt, fused_r, fused_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [2:0]  ok_r, ok_nxt;
  logic [15:0] ot_r, ot_nxt, op_nxt_p, op_p_r;
  state_t      ret_r, ret_nxt;

  logic [SW-1:0]  s_rd, s_wa, act_a;
  logic [15:0]    r_txn, r_lim, r_ela, w_txn, w_lim, w_ela;
  logic           s_we, act_set, act_clr;
  logic [MAX_TXNS-1:0] active;
  logic [SW-1:0]  m_rd, m_wa, u_a;
  logic [MAX_PARTS*16-1:0] r_id, w_id;
  logic [MAX_PARTS-1:0] r_rdy, w_rdy, u_v, uses;
  logic           m_we, u_we;
  logic [MAX_TXNS*MAX_PARTS-1:0] used;

  logic [SW-1:0] cur;
  logic          free_f;
  logic [SW-1:0] free_s;
  logic [SW-1:0] exp_s;
  logic          hit_f, place_f, all_rdy;
  logic [PW-1:0] hit_m, place_m;
  logic [15:0]   ela_inc;
  logic [PW-1:0] mi;

  tpcc_slot_mem #(.MAX_TXNS(MAX_TXNS), .SW(SW)) u_slot (
    .clk, .rst_n, .rd_addr(s_rd), .rd_txn(r_txn), .rd_limit(r_lim),
    .rd_elapsed(r_ela), .wr_en(s_we), .wr_addr(s_wa), .wr_txn(w_txn),
    .wr_limit(w_lim), .wr_elapsed(w_ela), .act_set, .act_clr,
    .act_addr(act_a), .active
  );

  tpcc_member_mem #(.MAX_TXNS(MAX_TXNS), .MAX_PARTS(MAX_PARTS), .SW(SW)) u_mem (
    .clk, .rst_n, .rd_addr(m_rd), .rd_ident(r_id), .rd_ready(r_rdy),
    .wr_en(m_we), .wr_addr(m_wa), .wr_ident(w_id), .wr_ready(w_rdy),
    .used_wr(u_we), .used_addr(u_a), .used_val(u_v), .used
  );

  assign cur  = scan_r[SW-1:0];
  assign uses = used[wslot_r*MAX_PARTS +: MAX_PARTS];
  assign mi   = m_r[PW-1:0];
  assign ela_inc = (r_ela == 16'hFFFF) ? r_ela : r_ela + 16'd1;

  always_comb begin
    free_f = 1'b0;
    free_s = '0;
    for (int i = MAX_TXNS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_f = 1'b1;
        free_s = SW'(i);
      end
    end
  end

  always_comb begin
    exp_s = '0;
    for (int i = MAX_TXNS - 1; i >= 0; i--) begin
      if (exp_r[i]) begin
        exp_s = SW'(i);
      end
    end
  end

  // match/free search within the row just read (slot in wslot_r)
  always_comb begin
    hit_f = 1'b0;
    hit_m = '0;
    place_f = 1'b0;
    place_m = '0;
    all_rdy = 1'b1;
    for (int i = MAX_PARTS - 1; i >= 0; i--) begin
      if (uses[i] && r_id[i*16 +: 16] == pid_r) begin
        hit_f = 1'b1;
        hit_m = PW'(i);
      end
      if (!uses[i]) begin
        place_f = 1'b1;
        place_m = PW'(i);
      end
    end
    for (int i = 0; i < MAX_PARTS; i++) begin
      if (uses[i] && !(r_rdy[i] || (hit_f && hit_m == PW'(i)))) begin
        all_rdy = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idc_nxt = idc_r;
    bslot_nxt = bslot_r;
    wslot_nxt = wslot_r;
    exp_nxt = exp_r;
    bopen_nxt = bopen_r;
    bovf_nxt = bovf_r;
    scan_nxt = scan_r;
    m_nxt = m_r;
    commit_nxt = commit_r;
    ftxn_nxt = ftxn_r;
    fid_nxt = fid_r;
    frdy_nxt = frdy_r;
    fused_nxt = fused_r;
    ov_nxt = ov_r;
    ol_nxt = ol_r;
    ok_nxt = ok_r;
    ot_nxt = ot_r;
    op_nxt_p = op_p_r;
    ret_nxt = ret_r;
    s_rd = wslot_r;
    s_we = 1'b0;
    s_wa = wslot_r;
    w_txn = r_txn;
    w_lim = r_lim;
    w_ela = r_ela;
    act_set = 1'b0;
    act_clr = 1'b0;
    act_a = wslot_r;
    m_rd = wslot_r;
    m_we = 1'b0;
    m_wa = wslot_r;
    w_id = r_id;
    w_rdy = r_rdy;
    u_we = 1'b0;
    u_a = wslot_r;
    u_v = uses;
    in_ready = (state_r == S_IDLE) && !ov_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          scan_nxt = '0;
          exp_nxt = '0;
          unique case (op_t'(in_op))
            OP_START: begin
              if (!bopen_r) begin
                bopen_nxt = 1'b1;
                bovf_nxt = !free_f;
                bslot_nxt = free_s;
                wslot_nxt = free_s;
              end else begin
                wslot_nxt = bslot_r;
              end
              state_nxt = S_SRD;
            end
            OP_VOTE:  state_nxt = S_VSCAN;
            OP_TICK:  state_nxt = S_TRD;
            OP_NONE:  state_nxt = S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRD: begin
        state_nxt = S_SEXEC;
      end
      S_SEXEC: begin
        if (!bovf_r && !hit_f) begin
          if (place_f) begin
            w_id[place_m*16 +: 16] = pid_r;
            w_rdy[place_m] = 1'b0;
            m_we = 1'b1;
            u_we = 1'b1;
            u_v[place_m] = 1'b1;
          end else begin
            bovf_nxt = 1'b1;
          end
        end
        if (!lastm_r) begin
          state_nxt = S_IDLE;
        end else begin
          bopen_nxt = 1'b0;
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          op_nxt_p = '0;
          if (bovf_r || (!hit_f && !place_f)) begin
            bovf_nxt = 1'b0;
            u_we = !active[wslot_r];
            u_v = '0;
            m_we = 1'b0;
            ok_nxt = K_REFUSED;
            ot_nxt = '0;
          end else begin
            idc_nxt = idc_r + 1'b1;
            s_we = 1'b1;
            w_txn = 16'(idc_r + 1'b1);
            w_lim = tmo_r;
            w_ela = '0;
            act_set = 1'b1;
            ok_nxt = K_STARTED;
            ot_nxt = 16'(idc_r + 1'b1);
          end
          ret_nxt = S_IDLE;
          state_nxt = S_OUT;
        end
      end
      S_VSCAN: begin
        s_rd = cur;
        if (scan_r == CW'(MAX_TXNS)) begin
          state_nxt = S_IDLE;
        end else if (active[cur]) begin
          state_nxt = S_VMRD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_VMRD: begin
        s_rd = cur;
        m_rd = cur;
        if (r_txn == tid_r) begin
          wslot_nxt = cur;
          state_nxt = S_VMEXEC;
        end else begin
          scan_nxt = scan_r + 1'b1;
          state_nxt = S_VSCAN;
        end
      end
      S_VMEXEC: begin
        if (!hit_f) begin
          state_nxt = S_IDLE;
        end else if (succ_r) begin
          w_rdy[hit_m] = 1'b1;
          m_we = 1'b1;
          if (all_rdy) begin
            commit_nxt = 1'b1;
            ftxn_nxt = r_txn;
            fid_nxt = r_id;
            frdy_nxt = w_rdy;
            fused_nxt = uses;
            m_nxt = '0;
            ret_nxt = S_IDLE;
            state_nxt = S_FEMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          commit_nxt = 1'b0;
          ftxn_nxt = r_txn;
          fid_nxt = r_id;
          frdy_nxt = r_rdy;
          frdy_nxt[hit_m] = 1'b0;
          fused_nxt = uses;
          m_nxt = '0;
          ret_nxt = S_IDLE;
          state_nxt = S_FEMIT;
        end
      end
      S_TRD: begin
        s_rd = cur;
        m_rd = cur;
        if (scan_r == CW'(MAX_TXNS)) begin
          if (exp_r != '0) begin
            s_rd = exp_s;
            m_rd = exp_s;
            wslot_nxt = exp_s;
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (active[cur]) begin
          state_nxt = S_TEXEC;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_TEXEC: begin
        s_rd = cur;
        m_rd = cur;
        s_we = 1'b1;
        s_wa = cur;
        w_ela = ela_inc;
        scan_nxt = scan_r + 1'b1;
        if (ela_inc > r_lim) begin
          exp_nxt[cur] = 1'b1;
        end
        state_nxt = S_TRD;
      end
      S_FRD: begin
        commit_nxt = 1'b0;
        ftxn_nxt = r_txn;
        fid_nxt = r_id;
        frdy_nxt = r_rdy;
        fused_nxt = uses;
        m_nxt = '0;
        exp_nxt[wslot_r] = 1'b0;
        ret_nxt = S_TRD;
        state_nxt = S_FEMIT;
      end
      S_FEMIT: begin
        if (m_r == QW'(MAX_PARTS)) begin
          state_nxt = S_FEND;
        end else if (!ov_r || out_ready) begin
          m_nxt = m_r + 1'b1;
          if (fused_r[mi] && (commit_r || frdy_r[mi])) begin
            ov_nxt = 1'b1;
            ol_nxt = 1'b0;
            ok_nxt = commit_r ? K_COMMIT : K_ROLLBACK;
            ot_nxt = ftxn_r;
            op_nxt_p = fid_r[mi*16 +: 16];
          end
        end
      end
      S_FEND: begin
        if (!ov_r || out_ready) begin
          act_clr = 1'b1;
          u_we = 1'b1;
          u_v = '0;
          ov_nxt = 1'b1;
          ok_nxt = commit_r ? K_DONE : K_FAILED;
          ot_nxt = ftxn_r;
          op_nxt_p = '0;
          ol_nxt = (exp_r == '0);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (ret_r == S_TRD && exp_r != '0) begin
          s_rd = exp_s;
          m_rd = exp_s;
          wslot_nxt = exp_s;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idc_r <= '0;
      bopen_r <= 1'b0;
      bovf_r <= 1'b0;
      ov_r <= 1'b0;
      bslot_r <= '0;
      wslot_r <= '0;
    end else begin
      state_r <= state_nxt;
      idc_r <= idc_nxt;
      bopen_r <= bopen_nxt;
      bovf_r <= bovf_nxt;
      ov_r <= ov_nxt;
      bslot_r <= bslot_nxt;
      wslot_r <= wslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tid_r <= in_txn_id;
      pid_r <= in_participant_id;
      succ_r <= in_success;
      lastm_r <= in_last_member;
      tmo_r <= in_timeout_ticks;
    end
    scan_r <= scan_nxt;
    exp_r <= exp_nxt;
    m_r <= m_nxt;
    commit_r <= commit_nxt;
    ftxn_r <= ftxn_nxt;
    fid_r <= fid_nxt;
    frdy_r <= frdy_nxt;
    fused_r <= fused_nxt;
    ol_r <= ol_nxt;
    ok_r <= ok_nxt;
    ot_r <= ot_nxt;
    op_p_r <= op_nxt_p;
    ret_r <= ret_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_result_txn = ot_r;
  assign out_target_participant = op_p_r;
  assign out_last = ol_r;

endmodule

### hw/rtl/tpcc_slot_mem.sv
// Transaction slot table: active bits in flops, id/limit/elapsed in a
// synchronous memory. Depends on tpcc_pkg.
module tpcc_slot_mem import tpcc_pkg::*; #(
  parameter int MAX_TXNS = DefMaxTxns,
  parameter int SW       = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SW-1:0]    rd_addr,
  output logic [15:0]      rd_txn,
  output logic [15:0]      rd_limit,
  output logic [15:0]      rd_elapsed,
  input  logic             wr_en,
  input  logic [SW-1:0]    wr_addr,
  input  logic [15:0]      wr_txn,
  input  logic [15:0]      wr_limit,
  input  logic [15:0]      wr_elapsed,
  input  logic             act_set,
  input  logic             act_clr,
  input  logic [SW-1:0]    act_addr,
  output logic [MAX_TXNS-1:0] active
);

  logic [47:0] mem [MAX_TXNS];
  logic [47:0] rd_r;
  logic [MAX_TXNS-1:0] active_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_txn, wr_limit, wr_elapsed};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (act_set) begin
      active_r[act_addr] <= 1'b1;
    end else if (act_clr) begin
      active_r[act_addr] <= 1'b0;
    end
  end

  assign rd_txn     = rd_r[47:32];
  assign rd_limit   = rd_r[31:16];
  assign rd_elapsed = rd_r[15:0];
  assign active     = active_r;

endmodule

### hw/rtl/tpcc_member_mem.sv
// Participant table: one row of MAX_PARTS idents/ready bits per slot in a
// synchronous memory; used bits in flops. Depends on tpcc_pkg.
module tpcc_member_mem import tpcc_pkg::*; #(
  parameter int MAX_TXNS  = DefMaxTxns,
  parameter int MAX_PARTS = DefMaxParts,
  parameter int SW        = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SW-1:0]             rd_addr,
  output logic [MAX_PARTS*16-1:0]   rd_ident,
  output logic [MAX_PARTS-1:0]      rd_ready,
  input  logic                      wr_en,
  input  logic [SW-1:0]             wr_addr,
  input  logic [MAX_PARTS*16-1:0]   wr_ident,
  input  logic [MAX_PARTS-1:0]      wr_ready,
  input  logic                      used_wr,
  input  logic [SW-1:0]             used_addr,
  input  logic [MAX_PARTS-1:0]      used_val,
  output logic [MAX_TXNS*MAX_PARTS-1:0] used
);

  localparam int RW = MAX_PARTS * 17;

  logic [RW-1:0] mem [MAX_TXNS];
  logic [RW-1:0] rd_r;
  logic [MAX_TXNS*MAX_PARTS-1:0] used_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ident, wr_ready};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (used_wr) begin
      used_r[used_addr*MAX_PARTS +: MAX_PARTS] <= used_val;
    end
  end

  assign rd_ident = rd_r[RW-1:MAX_PARTS];
  assign rd_ready = rd_r[MAX_PARTS-1:0];
  assign used     = used_r;

endmodule

### hw/rtl/tpcc_checker.sv
// Port-level checks for the coordinator, bound to the top level.
// Depends on tpcc_pkg.
module tpcc_checker import tpcc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_result_txn,
  input logic [15:0] out_target_participant
);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during result burst");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= K_REFUSED) else $error("bad result kind");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_REFUSED) |-> out_result_txn == '0)
    else $error("refused start carries a txn");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_COMMIT && out_kind != K_ROLLBACK)
    |-> out_target_participant == '0)
    else $error("status beat carries a participant");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind)))
    else $error("result beat dropped");

endmodule

bind two_phase_commit_coordinator tpcc_checker u_tpcc_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_kind,
  .out_result_txn, .out_target_participant
);

### sim/two_phase_commit_coordinator_tb.sv
// Testbench for the two-phase commit coordinator: directed and random beats,
// predicted against an in-bench transaction table model. Depends on tpcc_pkg.
`timescale 1ns / 100ps

module two_phase_commit_coordinator_tb;
  import tpcc_pkg::*;

  localparam int NT = DefMaxTxns;
  localparam int NP = DefMaxParts;
  localparam int NM = NT * NP;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    op_t         op;
    logic [15:0] txn;
    logic [15:0] pid;
    logic        ok;
    logic        lastm;
    logic [15:0] tmo;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] txn;
    logic [15:0] part;
    logic        last;
  } event_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_success, in_last_member;
  logic [1:0] in_op;
  logic [15:0] in_txn_id, in_participant_id, in_timeout_ticks;
  logic out_valid, out_ready, out_last;
  logic [2:0] out_kind;
  logic [15:0] out_result_txn, out_target_participant;

  two_phase_commit_coordinator uut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  item_t  pending_q[$];
  event_t events_q[$];
  int errors = 0;
  bit quiet = 0;
  int watch = 0;

  // predictor state
  bit          t_act[NT];
  logic [15:0] t_id[NT], t_lim[NT], t_el[NT];
  bit          m_used[NM], m_rdy[NM];
  logic [15:0] m_id[NM];
  logic [15:0] id_ctr;
  int          b_slot;
  bit          b_open, b_ovf;

  function automatic void queue_item(item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void push_event(kind_t k, logic [15:0] t, logic [15:0] p);
    event_t e;
    e.kind = k; e.txn = t; e.part = p; e.last = 1'b0;
    events_q.insert(events_q.size(), e);
  endfunction

  function automatic void free_txn(int s);
    t_act[s] = 0;
    for (int m = 0; m < NP; m++) m_used[s*NP+m] = 0;
  endfunction

  function automatic void close_txn(int s, bit commit);
    for (int m = 0; m < NP; m++) begin
      int e = s*NP + m;
      if (m_used[e]) begin
        if (commit) push_event(K_COMMIT, t_id[s], m_id[e]);
        else if (m_rdy[e]) push_event(K_ROLLBACK, t_id[s], m_id[e]);
      end
    end
    push_event(commit ? K_DONE : K_FAILED, t_id[s], 16'd0);
    free_txn(s);
  endfunction

  function automatic void predict_coordinator(item_t it);
    int n0, s, m;
    bit found, placed, all;
    n0 = events_q.size();
    if (it.op == OP_START) begin
      if (!b_open) begin
        b_open = 1; b_ovf = 1; b_slot = 0;
        for (s = 0; s < NT; s++)
          if (!t_act[s]) begin b_slot = s; b_ovf = 0; break; end
      end
      if (!b_ovf) begin
        found = 0; placed = 0;
        for (m = 0; m < NP; m++)
          if (m_used[b_slot*NP+m] && m_id[b_slot*NP+m] == it.pid) found = 1;
        if (!found) begin
          for (m = 0; m < NP && !placed; m++)
            if (!m_used[b_slot*NP+m]) begin
              m_used[b_slot*NP+m] = 1; m_id[b_slot*NP+m] = it.pid;
              m_rdy[b_slot*NP+m] = 0; placed = 1;
            end
          if (!placed) b_ovf = 1;
        end
      end
      if (it.lastm) begin
        b_open = 0;
        if (b_ovf) begin
          if (!t_act[b_slot]) free_txn(b_slot);
          b_ovf = 0;
          push_event(K_REFUSED, 16'd0, 16'd0);
        end else begin
          id_ctr = id_ctr + 16'd1;
          t_act[b_slot] = 1; t_id[b_slot] = id_ctr;
          t_lim[b_slot] = it.tmo; t_el[b_slot] = 16'd0;
          push_event(K_STARTED, id_ctr, 16'd0);
        end
      end
    end else if (it.op == OP_VOTE) begin
      for (s = 0; s < NT; s++) if (t_act[s] && t_id[s] == it.txn) break;
      if (s < NT) begin
        for (m = 0; m < NP; m++)
          if (m_used[s*NP+m] && m_id[s*NP+m] == it.pid) break;
        if (m < NP) begin
          m_rdy[s*NP+m] = it.ok;
          if (it.ok) begin
            all = 1;
            for (int k = 0; k < NP; k++)
              if (m_used[s*NP+k] && !m_rdy[s*NP+k]) all = 0;
            if (all) close_txn(s, 1);
          end else close_txn(s, 0);
        end
      end
    end else if (it.op == OP_TICK) begin
      for (s = 0; s < NT; s++)
        if (t_act[s]) begin
          if (t_el[s] != 16'hFFFF) t_el[s] = t_el[s] + 16'd1;
          if (t_el[s] > t_lim[s]) close_txn(s, 0);
        end
    end
    if (events_q.size() > n0) events_q[events_q.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, event_t got, event_t want);
    errors++;
    $display("mismatch %s: got k%0d t%0h p%0h l%0b, want k%0d t%0h p%0h l%0b", what,
             got.kind, got.txn, got.part, got.last, want.kind, want.txn, want.part,
             want.last);
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_coordinator(pending_q.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--; in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 8) - 1; in_valid <= 1'b0;
        end else if (pending_q.size() > (in_valid && in_ready ? 0 : 0)) begin
          it = pending_q[0];
          in_valid <= 1'b1; in_op <= it.op; in_txn_id <= it.txn;
          in_participant_id <= it.pid; in_success <= it.ok;
          in_last_member <= it.lastm; in_timeout_ticks <= it.tmo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    event_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = kind_t'(out_kind); got.txn = out_result_txn;
        got.part = out_target_participant; got.last = out_last;
        if (events_q.size() == 0) begin
          want = '0; report_mismatch("unexpected", got, want);
        end else begin
          want = events_q.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", got, want);
          else if (got.txn != want.txn) report_mismatch("txn", got, want);
          else if (got.part != want.part) report_mismatch("participant", got, want);
          else if (got.last != want.last) report_mismatch("last", got, want);
        end
      end
      if (out_gap > 0) begin
        out_gap--; out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 8) - 1; out_ready <= 1'b0;
      end else out_ready <= 1'b1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) watch <= 0;
      else watch <= watch + 1;
    end
  end

  always @(posedge clk) begin
    if (watch >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic item_t mk(op_t op, logic [15:0] txn, logic [15:0] pid,
                               logic ok, logic lastm, logic [15:0] tmo);
    item_t it;
    it.op = op; it.txn = txn; it.pid = pid; it.ok = ok; it.lastm = lastm; it.tmo = tmo;
    return it;
  endfunction

  // random start run; pids drawn from a small pool so votes hit
  task automatic add_start(int n, logic [15:0] tmo);
    for (int i = 0; i < n; i++)
      queue_item(mk(OP_START, 16'($urandom), 16'($urandom_range(0, 6)),
                    1'($urandom), (i == n-1), tmo));
  endtask

  // ids are tracked at build time; rough guess suffices for random votes
  logic [15:0] guess_id = 0;

  initial begin
    int n;
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
    in_op = 2'd0; in_txn_id = 16'd0; in_participant_id = 16'd0;
    in_success = 1'b0; in_last_member = 1'b0; in_timeout_ticks = 16'd0;
    id_ctr = 16'd0; b_open = 0; b_ovf = 0; b_slot = 0;
    for (int i = 0; i < NT; i++) begin t_act[i] = 0; t_id[i] = 0; t_lim[i] = 0; t_el[i] = 0; end
    for (int i = 0; i < NM; i++) begin m_used[i] = 0; m_rdy[i] = 0; m_id[i] = 0; end

    // directed: commit, merge, failed vote, overflow, unknown, op none, ticks
    queue_item(mk(OP_START, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF));
    queue_item(mk(OP_START, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF));
    queue_item(mk(OP_VOTE, 16'd1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
    queue_item(mk(OP_START, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0));
    queue_item(mk(OP_START, 16'd0, 16'd5, 1'b0, 1'b1, 16'd0));
    queue_item(mk(OP_VOTE, 16'd2, 16'd0, 1'b1, 1'b0, 16'd0));
    queue_item(mk(OP_VOTE, 16'd2, 16'd5, 1'b0, 1'b0, 16'd0));
    for (int i = 0; i < 5; i++)
      queue_item(mk(OP_START, 16'd0, 16'(i+10), 1'b0, (i == 4), 16'd3));
    queue_item(mk(OP_START, 16'd0, 16'd7, 1'b0, 1'b1, 16'd0));
    queue_item(mk(OP_VOTE, 16'd3, 16'd7, 1'b1, 1'b0, 16'd0));
    queue_item(mk(OP_VOTE, 16'hFFFF, 16'd7, 1'b1, 1'b0, 16'd0));
    queue_item(mk(OP_VOTE, 16'd3, 16'hABCD, 1'b0, 1'b0, 16'd0));
    queue_item(mk(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
    queue_item(mk(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0));
    queue_item(mk(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0));
    // fill the table to force a table-full refusal
    for (int i = 0; i < NT + 1; i++)
      queue_item(mk(OP_START, 16'd0, 16'd1, 1'b0, 1'b1, 16'hFFFF));
    queue_item(mk(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0));
    guess_id = 16'd12;
    for (int i = 4; i <= 12; i++)
      queue_item(mk(OP_VOTE, 16'(i), 16'd1, 1'b1, 1'b0, 16'd0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // random: mostly well-formed starts and votes against recent ids
    n = 0;
    while (n < 160) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_start($urandom_range(1, 6), ($urandom_range(0, 3) == 0) ?
                    16'($urandom) : 16'($urandom_range(0, 12)));
          guess_id++; n += 3;
        end
        3, 4, 5, 6: begin
          queue_item(mk(OP_VOTE, guess_id - 16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 6)), ($urandom_range(0, 5) != 0),
                        1'($urandom), 16'($urandom)));
          n++;
        end
        7, 8: begin
          queue_item(mk(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
                        1'($urandom), 16'($urandom)));
          n++;
        end
        default: begin
          queue_item(mk(op_t'($urandom_range(1, 3)), 16'($urandom),
                        16'($urandom), 1'($urandom), 1'($urandom),
                        16'($urandom)));
          n++;
        end
      endcase
    end

    while (pending_q.size() >= 40) @(posedge clk);
    quiet = 1;
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (events_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && events_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tpcc_pkg.sv
hw/rtl/tpcc_slot_mem.sv
hw/rtl/tpcc_member_mem.sv
hw/rtl/two_phase_commit_coordinator.sv
hw/rtl/tpcc_checker.sv
sim/two_phase_commit_coordinator_tb.sv
